// ===== design/ggs_pkg.sv =====
// Shared types, constants and the arctangent table for the go-to-goal steering pipeline.
package ggs_pkg;

  // Fixed-point formats
  localparam int POS_W    = 16;  // Q5.11 positions
  localparam int ANG_W    = 16;  // Q3.13 angles
  localparam int CFG_W    = 16;  // widest register
  localparam int LIM_W    = 15;  // 15-bit registers and outputs
  localparam int DIFF_W   = POS_W + 1;
  localparam int SQ_W     = 2 * POS_W;       // one square, nonnegative
  localparam int REM_W    = SQ_W + 1;        // sum of two squares
  localparam int DIST_W   = 17;              // floor(sqrt) of a REM_W value
  localparam int TRY_W    = REM_W + 2;
  localparam int PRESCALE = 12;
  localparam int CW       = 32;              // CORDIC x/y width, covers gain
  localparam int ZW       = 18;              // CORDIC angle accumulator
  localparam int ERR_W    = 19;
  localparam int PROD_W   = CFG_W + DIST_W;
  localparam int GAIN_SHIFT = 12;
  localparam int ATAN_W   = 13;

  localparam logic [LIM_W-1:0] ANG_PI     = 15'd25736;
  localparam logic [LIM_W+1:0] ANG_TWO_PI = 17'd51472;

  // Register indexes
  typedef enum logic [2:0] {
    REG_GOAL_X        = 3'd0,
    REG_GOAL_Y        = 3'd1,
    REG_SPEED_GAIN    = 3'd2,
    REG_SPEED_LIMIT   = 3'd3,
    REG_ARRIVE_RADIUS = 3'd4,
    REG_AIM_TOLERANCE = 3'd5
  } ggs_reg_e;

  localparam logic signed [POS_W-1:0] RST_GOAL_X        = 16'sd2048;
  localparam logic signed [POS_W-1:0] RST_GOAL_Y        = 16'sd2048;
  localparam logic [CFG_W-1:0]        RST_SPEED_GAIN    = 16'd4096;
  localparam logic [LIM_W-1:0]        RST_SPEED_LIMIT   = 15'd6144;
  localparam logic [LIM_W-1:0]        RST_ARRIVE_RADIUS = 15'd205;
  localparam logic [LIM_W-1:0]        RST_AIM_TOLERANCE = 15'd1638;

  // Work carried through the rotation / square-root stages
  typedef struct packed {
    logic signed [CW-1:0]    cx;
    logic signed [CW-1:0]    cy;
    logic signed [ZW-1:0]    cz;
    logic [REM_W-1:0]        rem;
    logic [DIST_W-1:0]       root;
    logic signed [ANG_W-1:0] hd;
  } ggs_work_t;

  typedef struct packed {
    logic [LIM_W-1:0] forward_speed;
    logic [LIM_W-1:0] turn_rate;
  } ggs_result_t;

  // atan(2^-i) in Q3.13, rounded
  function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned i);
    logic [ATAN_W-1:0] v;
    case (i)
      0:       v = 13'd6434;
      1:       v = 13'd3798;
      2:       v = 13'd2007;
      3:       v = 13'd1019;
      4:       v = 13'd511;
      5:       v = 13'd256;
      6:       v = 13'd128;
      7:       v = 13'd64;
      8:       v = 13'd32;
      9:       v = 13'd16;
      10:      v = 13'd8;
      11:      v = 13'd4;
      12:      v = 13'd2;
      13:      v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/ggs_front.sv =====
// Front stages: goal offset, squares with CORDIC pre-rotation, sum of squares.
module ggs_front (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [ggs_pkg::POS_W-1:0]   goal_x,
  input  logic signed [ggs_pkg::POS_W-1:0]   goal_y,
  input  logic signed [ggs_pkg::POS_W-1:0]   pos_x,
  input  logic signed [ggs_pkg::POS_W-1:0]   pos_y,
  input  logic signed [ggs_pkg::ANG_W-1:0]   heading,
  output ggs_pkg::ggs_work_t                 work_o
);
  import ggs_pkg::*;

  // stage 0
  logic signed [DIFF_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [ANG_W-1:0]  hd0_r;
  // stage 1
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic signed [2*DIFF_W-1:0] px, py;
  logic signed [CW-1:0]     xs, ys;
  logic signed [CW-1:0]     cx1_r, cy1_r, cx1_nxt, cy1_nxt;
  logic signed [ZW-1:0]     cz1_r, cz1_nxt;
  logic signed [ANG_W-1:0]  hd1_r;
  // stage 2
  ggs_work_t                work_r, work_nxt;

  always_comb begin
    dx_nxt = $signed({goal_x[POS_W-1], goal_x}) - $signed({pos_x[POS_W-1], pos_x});
    dy_nxt = $signed({goal_y[POS_W-1], goal_y}) - $signed({pos_y[POS_W-1], pos_y});
  end

  always_comb begin
    px = $signed({{DIFF_W{dx_r[DIFF_W-1]}}, dx_r}) * $signed({{DIFF_W{dx_r[DIFF_W-1]}}, dx_r});
    py = $signed({{DIFF_W{dy_r[DIFF_W-1]}}, dy_r}) * $signed({{DIFF_W{dy_r[DIFF_W-1]}}, dy_r});
    sqx_nxt = px[SQ_W-1:0];
    sqy_nxt = py[SQ_W-1:0];
    xs = $signed({{(CW-DIFF_W-PRESCALE){dx_r[DIFF_W-1]}}, dx_r, {PRESCALE{1'b0}}});
    ys = $signed({{(CW-DIFF_W-PRESCALE){dy_r[DIFF_W-1]}}, dy_r, {PRESCALE{1'b0}}});
    // left half-plane: rotate by pi so the iterations start with x >= 0
    if (dx_r[DIFF_W-1]) begin
      cx1_nxt = -xs;
      cy1_nxt = -ys;
      cz1_nxt = dy_r[DIFF_W-1] ? -$signed({{(ZW-LIM_W){1'b0}}, ANG_PI})
                               :  $signed({{(ZW-LIM_W){1'b0}}, ANG_PI});
    end else begin
      cx1_nxt = xs;
      cy1_nxt = ys;
      cz1_nxt = '0;
    end
  end

  always_comb begin
    work_nxt.cx   = cx1_r;
    work_nxt.cy   = cy1_r;
    work_nxt.cz   = cz1_r;
    work_nxt.rem  = {1'b0, sqx_r} + {1'b0, sqy_r};
    work_nxt.root = '0;
    work_nxt.hd   = hd1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      hd0_r  <= heading;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      cx1_r  <= cx1_nxt;
      cy1_r  <= cy1_nxt;
      cz1_r  <= cz1_nxt;
      hd1_r  <= hd0_r;
      work_r <= work_nxt;
    end
  end

  assign work_o = work_r;

endmodule

// ===== design/ggs_iter.sv =====
// One pipeline stage: CORDIC vectoring micro-rotation and/or a square-root digit.
module ggs_iter #(
  parameter int IDX          = 0,
  parameter int CORDIC_STEPS = 14
) (
  input  logic               clk,
  input  logic               adv,
  input  ggs_pkg::ggs_work_t work_i,
  output ggs_pkg::ggs_work_t work_o
);
  import ggs_pkg::*;

  localparam bit DO_ROT  = (IDX < CORDIC_STEPS);
  localparam bit DO_ROOT = (IDX < DIST_W);
  localparam int J       = DO_ROOT ? (DIST_W - 1 - IDX) : 0;

  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] zstep;
  logic [TRY_W-1:0]     trial;
  ggs_work_t            work_r, work_nxt;

  always_comb begin
    xs    = work_i.cx >>> IDX;
    ys    = work_i.cy >>> IDX;
    zstep = $signed({{(ZW-ATAN_W){1'b0}}, atan_entry(IDX)});
    // (root + 2^J)^2 - root^2
    trial = ({{(TRY_W-DIST_W){1'b0}}, work_i.root} << (J + 1))
          + ({{(TRY_W-1){1'b0}}, 1'b1} << (2 * J));
    work_nxt = work_i;
    if (DO_ROT) begin
      if (!work_i.cy[CW-1]) begin
        work_nxt.cx = work_i.cx + ys;
        work_nxt.cy = work_i.cy - xs;
        work_nxt.cz = work_i.cz + zstep;
      end else begin
        work_nxt.cx = work_i.cx - ys;
        work_nxt.cy = work_i.cy + xs;
        work_nxt.cz = work_i.cz - zstep;
      end
    end
    if (DO_ROOT && ({2'b00, work_i.rem} >= trial)) begin
      work_nxt.rem  = work_i.rem - trial[REM_W-1:0];
      work_nxt.root = work_i.root | ({{(DIST_W-1){1'b0}}, 1'b1} << J);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      work_r <= work_nxt;
    end
  end

  assign work_o = work_r;

endmodule

// ===== design/ggs_decide.sv =====
// Back stage: wrapped heading error, gain product, then stop/turn/drive select.
module ggs_decide (
  input  logic                         clk,
  input  logic                         adv,
  input  ggs_pkg::ggs_work_t           work_i,
  input  logic [ggs_pkg::CFG_W-1:0]    speed_gain,
  input  logic [ggs_pkg::LIM_W-1:0]    speed_limit,
  input  logic [ggs_pkg::LIM_W-1:0]    arrive_radius,
  input  logic [ggs_pkg::LIM_W-1:0]    aim_tolerance,
  output ggs_pkg::ggs_result_t         result_o
);
  import ggs_pkg::*;

  localparam logic signed [ERR_W-1:0] PI_S  = $signed({{(ERR_W-LIM_W){1'b0}}, ANG_PI});
  localparam logic signed [ERR_W-1:0] PI2_S =
    $signed({{(ERR_W-LIM_W-2){1'b0}}, ANG_TWO_PI});

  logic signed [ERR_W-1:0]  err_raw, err_nxt, err_r, err_abs;
  logic [PROD_W-1:0]        prod_r;
  logic                     far_r;
  logic [PROD_W-GAIN_SHIFT-1:0] speed_raw;
  logic [LIM_W-1:0]         speed_sat, aerr;

  always_comb begin
    err_raw = $signed({{(ERR_W-ZW){work_i.cz[ZW-1]}}, work_i.cz})
            - $signed({{(ERR_W-ANG_W){work_i.hd[ANG_W-1]}}, work_i.hd});
    // one step of 2*pi is always enough for this range
    if (err_raw > PI_S) begin
      err_nxt = err_raw - PI2_S;
    end else if (err_raw < -PI_S) begin
      err_nxt = err_raw + PI2_S;
    end else begin
      err_nxt = err_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r  <= err_nxt;
      prod_r <= {{(PROD_W-CFG_W){1'b0}}, speed_gain}
              * {{(PROD_W-DIST_W){1'b0}}, work_i.root};
      far_r  <= (work_i.root > {{(DIST_W-LIM_W){1'b0}}, arrive_radius});
    end
  end

  always_comb begin
    err_abs   = err_r[ERR_W-1] ? -err_r : err_r;
    aerr      = err_abs[LIM_W-1:0];
    speed_raw = prod_r[PROD_W-1:GAIN_SHIFT];
    if (speed_raw > {{(PROD_W-GAIN_SHIFT-LIM_W){1'b0}}, speed_limit}) begin
      speed_sat = speed_limit;
    end else begin
      speed_sat = speed_raw[LIM_W-1:0];
    end
    result_o = '0;
    if (far_r) begin
      if (aerr > aim_tolerance) begin
        result_o.turn_rate = aerr;
      end else begin
        result_o.forward_speed = speed_sat;
      end
    end
  end

endmodule

// ===== design/go_to_goal_steering_top.sv =====
// Top level of the go-to-goal steering pipeline: registers, stage chain, output skid.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid in_stall in_pos_x in_pos_y in_heading | pose in
//  out     | out_valid out_stall out_forward_speed          | command out
//          |   out_turn_rate                              |
//  cfg     | cfg_we cfg_index cfg_wdata                   | write only
//
// One pose transfer per cycle sustained while the output is not stalled. The
// number of iteration stages is the larger of CORDIC_STEPS and the 17 digit
// square-root stages, so by default the square-root stages set it.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
// A stalled result parks in a one-entry skid; in_stall is high only while the
// skid is full, and then the whole chain holds.
module go_to_goal_steering_top #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ggs_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [ggs_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [ggs_pkg::ANG_W-1:0]  in_heading,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ggs_pkg::LIM_W-1:0]         out_forward_speed,
  output logic [ggs_pkg::LIM_W-1:0]         out_turn_rate,
  // configuration
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [ggs_pkg::CFG_W-1:0]         cfg_wdata
);
  import ggs_pkg::*;

  localparam int LOOP_N = (CORDIC_STEPS > DIST_W) ? CORDIC_STEPS : DIST_W;
  // three front stages, LOOP_N iteration stages, one decide stage
  localparam int NST    = LOOP_N + 4;

  // configuration registers
  logic signed [POS_W-1:0] goal_x_r, goal_y_r;
  logic [CFG_W-1:0]        speed_gain_r;
  logic [LIM_W-1:0]        speed_limit_r, arrive_radius_r, aim_tolerance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r        <= RST_GOAL_X;
      goal_y_r        <= RST_GOAL_Y;
      speed_gain_r    <= RST_SPEED_GAIN;
      speed_limit_r   <= RST_SPEED_LIMIT;
      arrive_radius_r <= RST_ARRIVE_RADIUS;
      aim_tolerance_r <= RST_AIM_TOLERANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:        goal_x_r        <= $signed(cfg_wdata);
        REG_GOAL_Y:        goal_y_r        <= $signed(cfg_wdata);
        REG_SPEED_GAIN:    speed_gain_r    <= cfg_wdata;
        REG_SPEED_LIMIT:   speed_limit_r   <= cfg_wdata[LIM_W-1:0];
        REG_ARRIVE_RADIUS: arrive_radius_r <= cfg_wdata[LIM_W-1:0];
        REG_AIM_TOLERANCE: aim_tolerance_r <= cfg_wdata[LIM_W-1:0];
        default: ; // unmapped index: dropped
      endcase
    end
  end

  // Chain advances as one while the skid is empty.
  logic adv;
  logic skid_vld_r, skid_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  ggs_result_t skid_res_r, skid_res_nxt, out_res_r, out_res_nxt;
  logic [NST-1:0] vld_r;

  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // valid bits ride alongside the data stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // datapath
  ggs_work_t   wk [0:LOOP_N];
  ggs_result_t fin;

  ggs_front u_front (
    .clk     (clk),
    .adv     (adv),
    .goal_x  (goal_x_r),
    .goal_y  (goal_y_r),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .heading (in_heading),
    .work_o  (wk[0])
  );

  for (genvar k = 0; k < LOOP_N; k++) begin : g_iter
    ggs_iter #(
      .IDX          (k),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_iter (
      .clk    (clk),
      .adv    (adv),
      .work_i (wk[k]),
      .work_o (wk[k+1])
    );
  end

  ggs_decide u_decide (
    .clk           (clk),
    .adv           (adv),
    .work_i        (wk[LOOP_N]),
    .speed_gain    (speed_gain_r),
    .speed_limit   (speed_limit_r),
    .arrive_radius (arrive_radius_r),
    .aim_tolerance (aim_tolerance_r),
    .result_o      (fin)
  );

  // Output register plus skid. A finished item goes to the output register
  // when it is free or being taken, otherwise into the skid.
  logic take;
  assign take = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (skid_vld_r) begin
      if (take) begin
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (vld_r[NST-1]) begin
      if (!out_vld_r || take) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = fin;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_res_nxt = fin;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_forward_speed = out_res_r.forward_speed;
  assign out_turn_rate     = out_res_r.turn_rate;

  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a result while the output register is empty");

  // never drive and turn in the same command
  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_forward_speed == '0 || out_turn_rate == '0))
    else $error("forward speed and turn rate both nonzero");

  // wrapped error magnitude is bounded by pi
  a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_turn_rate <= ANG_PI))
    else $error("turn rate above pi");

  // a full skid freezes the chain
  a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |=> $stable(vld_r))
    else $error("pipeline moved while skid was full");

endmodule

// ===== verif/tb_go_to_goal_steering_top.sv =====
// Testbench for go_to_goal_steering_top: directed and random poses, each checked against a built-in steering predictor.
`timescale 1ns / 1ps

module tb_go_to_goal_steering_top;
  import ggs_pkg::*;

  localparam int STEPS       = 14;
  // pipeline depth: the larger of STEPS and the 17 square-root stages, plus front and decide stages
  localparam int LATENCY     = ((STEPS > 17) ? STEPS : 17) + 4;
  localparam longint HALF_TURN = longint'(ANG_PI);
  localparam longint FULL_TURN = longint'(ANG_TWO_PI);
  localparam logic [2:0] REG_SPARE = 3'd7;  // no register sits behind this index
  localparam int LONG_HOLD   = 400;         // cycles of receiver hold-off under pressure
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 7;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [ANG_W-1:0] hd;
  } pose_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input holds a known value from time zero
  // ---------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [ANG_W-1:0] in_heading = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [LIM_W-1:0]        out_forward_speed;
  logic [LIM_W-1:0]        out_turn_rate;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = REG_GOAL_X;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  go_to_goal_steering_top #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_heading       (in_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_forward_speed(out_forward_speed),
    .out_turn_rate    (out_turn_rate),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the register file, used by the predictor.
  // Only touched while the pipeline is empty.
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] goal_x_q = RST_GOAL_X;
  logic signed [POS_W-1:0] goal_y_q = RST_GOAL_Y;
  logic [CFG_W-1:0]        gain_q   = RST_SPEED_GAIN;
  logic [LIM_W-1:0]        limit_q  = RST_SPEED_LIMIT;
  logic [LIM_W-1:0]        radius_q = RST_ARRIVE_RADIUS;
  logic [LIM_W-1:0]        tol_q    = RST_AIM_TOLERANCE;

  pose_t       pose_backlog[$];   // poses waiting to be offered
  ggs_result_t cmd_expected[$];   // predicted commands, oldest first
  int          bad_results = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // atan(2^-i) in Q3.13, rounded to nearest
  function automatic longint atan_q13(int i);
    case (i)
      0:       return 6434;
      1:       return 3798;
      2:       return 2007;
      3:       return 1019;
      4:       return 511;
      5:       return 256;
      6:       return 128;
      7:       return 64;
      8:       return 32;
      9:       return 16;
      10:      return 8;
      11:      return 4;
      12:      return 2;
      13:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > n)
      probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // vectoring CORDIC; arithmetic shifts floor, as the hardware does
  function automatic longint bearing_q13(longint dy, longint dx);
    longint vx;
    longint vy;
    longint ang;
    longint sx;
    longint sy;
    vx  = dx * 4096;
    vy  = dy * 4096;
    ang = 0;
    if (vx < 0) begin
      ang = (vy >= 0) ? HALF_TURN : -HALF_TURN;
      vx  = -vx;
      vy  = -vy;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        ang = ang + atan_q13(i);
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        ang = ang - atan_q13(i);
      end
    end
    return ang;
  endfunction

  function automatic ggs_result_t steer_command(logic signed [POS_W-1:0] px,
                                                logic signed [POS_W-1:0] py,
                                                logic signed [ANG_W-1:0] hd);
    longint          dx;
    longint          dy;
    longint          err;
    longint          aerr;
    longint unsigned sq;
    longint unsigned reach;
    longint unsigned spd;
    ggs_result_t     cmd;
    dx    = longint'(goal_x_q) - longint'(px);
    dy    = longint'(goal_y_q) - longint'(py);
    sq    = dx * dx + dy * dy;
    reach = root_floor(sq);
    cmd   = '0;
    if (reach > radius_q) begin
      err = bearing_q13(dy, dx) - longint'(hd);
      while (err > HALF_TURN)
        err = err - FULL_TURN;
      while (err < -HALF_TURN)
        err = err + FULL_TURN;
      aerr = (err < 0) ? -err : err;
      if (aerr > tol_q) begin
        cmd.turn_rate = aerr[LIM_W-1:0];
      end else begin
        spd = (reach * gain_q) >> GAIN_SHIFT;
        if (spd > limit_q)
          spd = limit_q;
        cmd.forward_speed = spd[LIM_W-1:0];
      end
    end
    return cmd;
  endfunction

  // ---------------------------------------------------------------------------
  // Pose driver: bursts of random length, random gaps between them.
  // Each accepted transfer is predicted on the spot.
  // ---------------------------------------------------------------------------
  int    burst_left = 1;
  int    gap_left = 0;
  pose_t next_pose;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        cmd_expected.push_back(steer_command(in_pos_x, in_pos_y, in_heading));
      // the payload only moves once the current one is taken
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pose_backlog.size() != 0) begin
          next_pose = pose_backlog.pop_front();
          in_valid   <= 1'b1;
          in_pos_x   <= next_pose.x;
          in_pos_y   <= next_pose.y;
          in_heading <= next_pose.hd;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            // roughly a quarter of bursts run straight into the next
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command receiver: stall pattern of its own, plus long hold-offs on request.
  // Checks each accepted transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  ggs_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cmd_expected.size() == 0) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("unexpected command: forward_speed %0d turn_rate %0d",
                     out_forward_speed, out_turn_rate);
        end else begin
          want = cmd_expected.pop_front();
          if (out_forward_speed !== want.forward_speed ||
              out_turn_rate !== want.turn_rate) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
              $display("command mismatch: forward_speed exp %0d got %0d, turn_rate exp %0d got %0d",
                       want.forward_speed, out_forward_speed, want.turn_rate, out_turn_rate);
          end
        end
      end

      if (hold_asked != hold_served && hold_left == 0) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left <= 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 200);
        end
        mode_left = mode_left - 1;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767)
      return 16'sh7fff;
    if (v < -32768)
      return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint jitter(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic queue_pose(longint x, longint y, longint hd);
    pose_t p;
    p.x  = x[15:0];
    p.y  = y[15:0];
    p.hd = hd[15:0];
    @(negedge clk);
    pose_backlog.push_back(p);
  endtask

  // mix of far, near-goal (around the arrive circle) and mid-range poses;
  // half the headings aim close to the bearing so the drive branch is hit
  task automatic queue_random_poses(int count);
    pose_t  p;
    int     pick;
    longint aim;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        p.x = POS_W'($urandom());
        p.y = POS_W'($urandom());
      end else if (pick < 7) begin
        p.x = sat16(longint'(goal_x_q) + jitter(int'(radius_q) + 64));
        p.y = sat16(longint'(goal_y_q) + jitter(int'(radius_q) + 64));
      end else begin
        p.x = sat16(longint'(goal_x_q) + jitter(8192));
        p.y = sat16(longint'(goal_y_q) + jitter(8192));
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        aim  = bearing_q13(longint'(goal_y_q) - longint'(p.y),
                           longint'(goal_x_q) - longint'(p.x));
        p.hd = sat16(aim + jitter(int'(tol_q) + 40));
      end else if (pick < 8) begin
        p.hd = sat16(jitter(int'(HALF_TURN)));
      end else begin
        p.hd = ANG_W'($urandom());
      end
      @(negedge clk);
      pose_backlog.push_back(p);
    end
  endtask

  // the sequence pauses here until every queued pose is sent and every predicted command has come back
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pose_backlog.size() != 0 || in_valid || cmd_expected.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GOAL_X:        goal_x_q = val;
      REG_GOAL_Y:        goal_y_q = val;
      REG_SPEED_GAIN:    gain_q   = val;
      REG_SPEED_LIMIT:   limit_q  = val[LIM_W-1:0];
      REG_ARRIVE_RADIUS: radius_q = val[LIM_W-1:0];
      REG_AIM_TOLERANCE: tol_q    = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    write_reg(REG_GOAL_X, CFG_W'($urandom()));
    write_reg(REG_GOAL_Y, CFG_W'($urandom()));
    write_reg(REG_SPEED_GAIN, CFG_W'($urandom()));
    write_reg(REG_SPEED_LIMIT, CFG_W'($urandom()));
    // small radius most of the time, else anything the field holds
    write_reg(REG_ARRIVE_RADIUS,
              CFG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 1024) : $urandom()));
    write_reg(REG_AIM_TOLERANCE,
              CFG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 4000) : $urandom()));
    end_writes();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: goal (1,1), radius 205, tolerance 1638
    queue_pose(2048, 2048, 0);              // pose on the goal
    queue_pose(2048, 2048, -32768);         // on the goal, heading at the field minimum
    queue_pose(2048 - 205, 2048, 0);        // exactly on the arrive circle
    queue_pose(2048 - 206, 2048, 0);        // just outside it, straight ahead
    queue_pose(2048 + 4096, 2048, 0);       // goal behind: bearing at +pi
    queue_pose(2048 + 4096, 2048, 25736);   // facing it at +pi
    queue_pose(2048 + 4096, 2048, -25736);  // error wraps by a full turn
    queue_pose(2048 + 4096, 2049, 0);       // behind and below: start at -pi
    queue_pose(2048 + 4096, 2047, 0);       // behind and above: start at +pi
    queue_pose(2048, -32768, 12868);        // straight up, aligned: drive
    queue_pose(0, 0, 6434);                 // diagonal, aligned
    queue_pose(0, 0, -32768);               // heading outside +-pi
    queue_pose(-32768, -32768, 32767);      // far corner, heading well off the bearing: turn
    queue_pose(32767, 32767, -32768);
    queue_pose(-32768, 32767, 32767);
    queue_pose(32767, -32768, 12868);
    queue_random_poses(150);
    wait_drained();

    // extremes: widest difference vectors, zero radius and tolerance
    write_reg(REG_GOAL_X, 16'h8000);
    write_reg(REG_GOAL_Y, 16'h7fff);
    write_reg(REG_SPEED_GAIN, 16'hffff);
    write_reg(REG_SPEED_LIMIT, 16'h7fff);
    write_reg(REG_ARRIVE_RADIUS, 16'h0000);
    write_reg(REG_AIM_TOLERANCE, 16'h0000);
    write_reg(REG_SPARE, 16'hffff);         // must leave every register alone
    end_writes();
    queue_pose(32767, -32768, 0);           // dx = -65535, dy = +65535
    queue_pose(-32768, 32767, 0);           // on the goal with zero radius
    queue_pose(-32767, 32767, 0);           // one step away
    queue_pose(32767, 32767, 25736);
    queue_random_poses(150);
    wait_drained();

    // other corner, zero gain and limit, widest radius and tolerance
    write_reg(REG_GOAL_X, 16'h7fff);
    write_reg(REG_GOAL_Y, 16'h8000);
    write_reg(REG_SPEED_GAIN, 16'h0000);
    write_reg(REG_SPEED_LIMIT, 16'h0000);
    write_reg(REG_ARRIVE_RADIUS, 16'h7fff);
    write_reg(REG_AIM_TOLERANCE, 16'h7fff);
    end_writes();
    queue_pose(-32768, 32767, -32768);      // dx = +65535, dy = -65535
    queue_pose(32767, -32768, 0);
    queue_random_poses(120);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_settings();
      // hold the receiver off while the sender keeps going, so the
      // pipeline fills and in_stall rises
      if (ph == 1 || ph == 4)
        hold_asked++;
      queue_random_poses(180);
      wait_drained();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (bad_results == 0 && cmd_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
design/ggs_pkg.sv
design/ggs_front.sv
design/ggs_iter.sv
design/ggs_decide.sv
design/go_to_goal_steering_top.sv
verif/tb_go_to_goal_steering_top.sv
